### sv/tsa_pkg.sv
// Shared types and constants for the tanh/sigmoid activation pipeline.
`default_nettype none
package tsa_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int OUT_W           = 16;
   localparam int T_W             = 17;
   localparam int U_W             = 13;
   localparam int U2_W            = 26;
   localparam int SUM_W           = 27;
   localparam int NUM_W           = 40;
   localparam int DEN_W           = 29;
   localparam int DVD_W           = 44;
   localparam int DSR_W           = 30;
   localparam int QUO_W           = 15;
   localparam int STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

   localparam logic KIND_TANH    = 1'b0;
   localparam logic KIND_SIGMOID = 1'b1;

   localparam logic signed [T_W-1:0] T_MAX = 17'sd6144;
   localparam logic signed [T_W-1:0] T_MIN = -17'sd6144;

   localparam logic [DEN_W-1:0] FIFTEEN_Q22 = 29'd62914560;
   localparam logic [DSR_W-1:0] DSR_MIN     = 30'd125829120;

   localparam logic [QUO_W-1:0] TANH_FULL = 15'd16384;
   localparam logic [QUO_W-1:0] SIG_FULL  = 15'd8192;
   localparam logic [OUT_W-1:0] SIG_MID   = 16'd8192;
   localparam logic signed [OUT_W-1:0] OUT_HI = 16'sd16384;
   localparam logic signed [OUT_W-1:0] OUT_LO = -16'sd16384;

   typedef struct packed {
      logic [DSR_W-1:0] rem;
      logic [QUO_W-1:0] dvd_lo;
      logic [QUO_W-1:0] quo;
      logic [DSR_W-1:0] dsr;
      logic             neg;
      logic             kind;
   } div_item_type;

endpackage
`default_nettype wire

### sv/tsa_front.sv
// Front end: clamp, squaring, numerator and denominator, dividend setup.
`default_nettype none
module tsa_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [tsa_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic                                 kind,
   output logic                                      out_valid,
   output tsa_pkg::div_item_type                     out_item
);

   logic                           s0_valid_ff;
   logic [tsa_pkg::U_W-1:0]        s0_u_ff, s0_u_in;
   logic                           s0_neg_ff, s0_neg_in;
   logic                           s0_kind_ff;

   logic                           s1_valid_ff;
   logic [tsa_pkg::U_W-1:0]        s1_u_ff;
   logic [tsa_pkg::U2_W-1:0]       s1_u2_ff, s1_u2_in;
   logic                           s1_neg_ff;
   logic                           s1_kind_ff;

   logic                           s2_valid_ff;
   logic [tsa_pkg::NUM_W-1:0]      s2_num_ff, s2_num_in;
   logic [tsa_pkg::DEN_W-1:0]      s2_den_ff, s2_den_in;
   logic                           s2_neg_ff;
   logic                           s2_kind_ff;

   logic                           s3_valid_ff;
   tsa_pkg::div_item_type          s3_item_ff, s3_item_in;

   logic signed [tsa_pkg::T_W-1:0] t_raw;
   logic signed [tsa_pkg::T_W-1:0] t_clamp;
   logic [tsa_pkg::T_W-1:0]        t_mag;
   logic [tsa_pkg::SUM_W-1:0]      u2_sum;
   logic [tsa_pkg::DVD_W-1:0]      dvd;

   always_comb begin
      if (kind == tsa_pkg::KIND_SIGMOID) begin
         t_raw = {sample[tsa_pkg::SAMPLE_W-1], sample};
      end else begin
         t_raw = {sample, 1'b0};
      end
      if (t_raw > tsa_pkg::T_MAX) begin
         t_clamp = tsa_pkg::T_MAX;
      end else if (t_raw < tsa_pkg::T_MIN) begin
         t_clamp = tsa_pkg::T_MIN;
      end else begin
         t_clamp = t_raw;
      end
      s0_neg_in = t_clamp[tsa_pkg::T_W-1];
      t_mag     = s0_neg_in ? 17'(-t_clamp) : 17'(t_clamp);
      s0_u_in   = t_mag[tsa_pkg::U_W-1:0];
   end

   assign s1_u2_in = tsa_pkg::U2_W'(s0_u_ff * s0_u_ff);

   always_comb begin
      u2_sum    = tsa_pkg::SUM_W'(s1_u2_ff) + tsa_pkg::SUM_W'(tsa_pkg::FIFTEEN_Q22);
      s2_num_in = tsa_pkg::NUM_W'(s1_u_ff) * tsa_pkg::NUM_W'(u2_sum);
      s2_den_in = {s1_u2_ff, 2'b00} + {1'b0, s1_u2_ff, 1'b0} + tsa_pkg::FIFTEEN_Q22;
   end

   // dividend = 2*num*2^(S-11) + den, divisor = 2*den
   always_comb begin
      if (s2_kind_ff == tsa_pkg::KIND_SIGMOID) begin
         dvd = {1'b0, s2_num_ff, 3'b000} + tsa_pkg::DVD_W'(s2_den_ff);
      end else begin
         dvd = {s2_num_ff, 4'b0000} + tsa_pkg::DVD_W'(s2_den_ff);
      end
      s3_item_in.rem    = {1'b0, dvd[tsa_pkg::DVD_W-1:tsa_pkg::QUO_W]};
      s3_item_in.dvd_lo = dvd[tsa_pkg::QUO_W-1:0];
      s3_item_in.quo    = '0;
      s3_item_in.dsr    = {s2_den_ff, 1'b0};
      s3_item_in.neg    = s2_neg_ff;
      s3_item_in.kind   = s2_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_u_ff    <= s0_u_in;
         s0_neg_ff  <= s0_neg_in;
         s0_kind_ff <= kind;
         s1_u_ff    <= s0_u_ff;
         s1_u2_ff   <= s1_u2_in;
         s1_neg_ff  <= s0_neg_ff;
         s1_kind_ff <= s0_kind_ff;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_kind_ff <= s1_kind_ff;
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

`ifndef SYNTH
   a_divisor_floor: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_item_ff.dsr >= tsa_pkg::DSR_MIN)
      else $error("divisor below its floor");
   a_dividend_fits: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_item_ff.rem < s3_item_ff.dsr)
      else $error("quotient would overflow its width");
   a_sign_pos_zero: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_u_ff == '0 |-> !s1_neg_ff)
      else $error("zero magnitude marked negative");
`endif
endmodule
`default_nettype wire

### sv/tsa_div_stage.sv
// One stage of the restoring divider: a few quotient bits per stage.
`default_nettype none
module tsa_div_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire tsa_pkg::div_item_type  in_item,
   output logic                        out_valid,
   output tsa_pkg::div_item_type       out_item
);

   logic                           valid_ff;
   tsa_pkg::div_item_type          item_ff, item_in;
   logic [tsa_pkg::DSR_W:0]        trial;
   logic                           qbit;

   always_comb begin
      item_in = in_item;
      trial   = '0;
      qbit    = 1'b0;
      for (int i = 0; i < tsa_pkg::STEPS_PER_STAGE; i++) begin
         trial          = {item_in.rem, item_in.dvd_lo[tsa_pkg::QUO_W-1]};
         item_in.dvd_lo = {item_in.dvd_lo[tsa_pkg::QUO_W-2:0], 1'b0};
         qbit           = (trial >= {1'b0, item_in.dsr});
         if (qbit) begin
            trial = trial - {1'b0, item_in.dsr};
         end
         item_in.rem = trial[tsa_pkg::DSR_W-1:0];
         item_in.quo = {item_in.quo[tsa_pkg::QUO_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

`ifndef SYNTH
   a_rem_below_dsr: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> item_ff.rem < item_ff.dsr)
      else $error("partial remainder not below divisor");
   a_dsr_carried: assert property (@(posedge clock) disable iff (reset)
      en && in_valid |=> item_ff.dsr == $past(in_item.dsr))
      else $error("divisor changed across stage");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> valid_ff == $past(valid_ff) && item_ff == $past(item_ff))
      else $error("stage moved while stalled");
`endif
endmodule
`default_nettype wire

### sv/tanh_sigmoid_activation_top.sv
// Top level of the Pade (3,2) tanh / sigmoid activation pipeline.
// Takes one Q5.10 sample per cycle and returns tanh (or sigmoid) in Q1.14,
// one transaction per cycle sustained while the output is not stalled, passing
// from the accepting edge to rsp_valid via ten registers: four front stages (clamp, square,
// numerator/denominator, dividend setup), five divider stages at three
// quotient bits each, and the output register. The rounded divide is what
// sets the depth. A stalled output halts the whole pipeline; req_stall is
// high only while rsp_valid and rsp_stall are both high. csr_write_data
// selects the mode (0 tanh, 1 sigmoid); write it only while the pipeline is empty.
`default_nettype none
module tanh_sigmoid_activation_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic                                csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [tsa_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [tsa_pkg::OUT_W-1:0]         rsp_activation_out
);

   logic                        csr_kind_ff;
   logic                        en;
   logic                        div_valid [0:tsa_pkg::DIV_STAGES];
   tsa_pkg::div_item_type       div_item  [0:tsa_pkg::DIV_STAGES];
   logic                        rsp_valid_ff;
   logic [tsa_pkg::OUT_W-1:0]   rsp_data_ff, rsp_data_in;
   tsa_pkg::div_item_type       last;
   logic [tsa_pkg::QUO_W-1:0]   lim;
   logic [tsa_pkg::QUO_W-1:0]   mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_kind_ff <= tsa_pkg::KIND_TANH;
      end else if (csr_write_enable) begin
         csr_kind_ff <= csr_write_data;
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   tsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .sample    (req_sample_in),
      .kind      (csr_kind_ff),
      .out_valid (div_valid[0]),
      .out_item  (div_item[0])
   );

   for (genvar g = 0; g < tsa_pkg::DIV_STAGES; g++) begin : g_div
      tsa_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[g]),
         .in_item   (div_item[g]),
         .out_valid (div_valid[g+1]),
         .out_item  (div_item[g+1])
      );
   end

   assign last = div_item[tsa_pkg::DIV_STAGES];

   always_comb begin
      lim = (last.kind == tsa_pkg::KIND_SIGMOID) ? tsa_pkg::SIG_FULL : tsa_pkg::TANH_FULL;
      mag = (last.quo > lim) ? lim : last.quo;
      if (last.kind == tsa_pkg::KIND_SIGMOID) begin
         rsp_data_in = last.neg ? tsa_pkg::SIG_MID - {1'b0, mag}
                                : tsa_pkg::SIG_MID + {1'b0, mag};
      end else begin
         rsp_data_in = last.neg ? 16'(-{1'b0, mag}) : {1'b0, mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid[tsa_pkg::DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_activation_out = rsp_data_ff;

`ifndef SYNTH
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_activation_out >= tsa_pkg::OUT_LO
                    && rsp_activation_out <= tsa_pkg::OUT_HI)
      else $error("activation outside +-1");
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid[tsa_pkg::DIV_STAGES] |-> last.quo < 15'd17200)
      else $error("quotient beyond approximant bound");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty output");
`endif
endmodule
`default_nettype wire
